>>> rtl/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types and constants for the LC-3 execute core.
// ----------------------------------------------------------------------------
`default_nettype none
package lc3_pkg;

	localparam logic [15:0] PC_RESET = 16'h3000;

	localparam logic [2:0] CC_NEG  = 3'd4;
	localparam logic [2:0] CC_ZERO = 3'd2;
	localparam logic [2:0] CC_POS  = 3'd1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_BADTRAP = 3'd2;
	localparam logic [2:0] ST_UNSUP   = 3'd3;
	localparam logic [2:0] ST_HALTED  = 3'd4;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0] TV_GETC  = 8'h20;
	localparam logic [7:0] TV_OUT   = 8'h21;
	localparam logic [7:0] TV_PUTS  = 8'h22;
	localparam logic [7:0] TV_IN    = 8'h23;
	localparam logic [7:0] TV_PUTSP = 8'h24;
	localparam logic [7:0] TV_HALT  = 8'h25;

	typedef enum logic [3:0] {
		CL_ALU, CL_BR, CL_JMP, CL_JSR, CL_LD, CL_LDR, CL_LDI,
		CL_ST, CL_STR, CL_STI, CL_TRAP, CL_BAD
	} op_class_t;

	typedef enum logic [1:0] {
		S_CLEAR, S_IDLE, S_RD1, S_RD2
	} state_t;

	typedef struct packed {
		op_class_t   cls;
		logic [7:0]  key;
		logic [11:0] bits;
		logic [3:0]  opcode;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  char_out;
		logic        char_valid;
		logic [15:0] reg_value;
		logic [2:0]  reg_index;
		logic        reg_written;
		logic [2:0]  cond_code;
		logic [15:0] next_pc;
	} result_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v == 16'd0) return CC_ZERO;
		if (v[15]) return CC_NEG;
		return CC_POS;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lc3_ram.sv
// ----------------------------------------------------------------------------
// lc3_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/lc3_front.sv
// ----------------------------------------------------------------------------
// lc3_front
// Accepts instruction beats, classifies them and queues them for execution.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_front
	import lc3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        block,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  opcode,
	input  wire logic [11:0] operand_bits,
	input  wire logic [7:0]  key_char,
	input  wire logic        pop,
	output head_t            head
);
	item_t      q_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	op_class_t  cls;
	logic       push;

	always_comb begin
		case (opcode)
			OP_ADD, OP_AND, OP_NOT, OP_LEA: cls = CL_ALU;
			OP_BR:   cls = CL_BR;
			OP_JMP:  cls = CL_JMP;
			OP_JSR:  cls = CL_JSR;
			OP_LD:   cls = CL_LD;
			OP_LDR:  cls = CL_LDR;
			OP_LDI:  cls = CL_LDI;
			OP_ST:   cls = CL_ST;
			OP_STR:  cls = CL_STR;
			OP_STI:  cls = CL_STI;
			OP_TRAP: cls = CL_TRAP;
			default: cls = CL_BAD;
		endcase
	end

	assign in_ready   = (cnt_q != 2'd2) && !block;
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= '{cls: cls, key: key_char, bits: operand_bits, opcode: opcode};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

>>> rtl/lc3_back.sv
// ----------------------------------------------------------------------------
// lc3_back
// Executes queued instructions against the register file and data memory.
// ----------------------------------------------------------------------------
`default_nettype none
module lc3_back
	import lc3_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire head_t       head,
	output logic             pop,
	output logic             clearing,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_pc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output result_t          out_data
);
	localparam int DEPTH = 1 << MEM_ADDR_BITS;

	state_t state_q, state_d;
	logic [15:0] rf_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic        running_q;
	logic [MEM_ADDR_BITS-1:0] clr_q;

	logic        out_free, start, finish;
	logic        mem_re, mem_we, rf_we, set_cc, halt;
	logic [15:0] mem_a, mem_wd, rdata;
	logic [MEM_ADDR_BITS-1:0] ram_addr;
	logic [15:0] ram_wd;
	result_t     res;

	item_t       it;
	logic [2:0]  dr, sr1, sr2;
	logic [15:0] pc1, off9, addr_pc, addr_base, opb, sr1v;

	assign it        = head.item;
	assign dr        = it.bits[11:9];
	assign sr1       = it.bits[8:6];
	assign sr2       = it.bits[2:0];
	assign sr1v      = rf_q[sr1];
	assign pc1       = pc_q + 16'd1;
	assign off9      = {{7{it.bits[8]}}, it.bits[8:0]};
	assign addr_pc   = pc1 + off9;
	assign addr_base = sr1v + {{10{it.bits[5]}}, it.bits[5:0]};
	assign opb       = it.bits[5] ? {{11{it.bits[4]}}, it.bits[4:0]} : rf_q[sr2];
	assign out_free  = !out_valid || out_ready;
	assign start     = (state_q == S_IDLE) && head.valid && out_free;
	assign clearing  = (state_q == S_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (start && running_q &&
				    (it.cls == CL_LD || it.cls == CL_LDR ||
				     it.cls == CL_LDI || it.cls == CL_STI)) state_d = S_RD1;
			end
			S_RD1: begin
				if (it.cls == CL_LDI) state_d = S_RD2;
				else if (out_free) state_d = S_IDLE;
			end
			S_RD2: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		finish = 1'b0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_a  = addr_pc;
		mem_wd = rf_q[dr];
		rf_we  = 1'b0;
		set_cc = 1'b0;
		halt   = 1'b0;
		res    = '0;
		res.next_pc = pc1;
		case (state_q)
			S_IDLE: begin
				if (start && !running_q) begin
					finish = 1'b1;
					res.next_pc = pc_q;
					res.status  = ST_HALTED;
				end else if (start) begin
					case (it.cls)
						CL_LD, CL_LDI, CL_STI: mem_re = 1'b1;
						CL_LDR: begin
							mem_re = 1'b1;
							mem_a  = addr_base;
						end
						CL_ST: begin
							mem_we = 1'b1;
							finish = 1'b1;
						end
						CL_STR: begin
							mem_we = 1'b1;
							mem_a  = addr_base;
							finish = 1'b1;
						end
						CL_ALU: begin
							finish = 1'b1;
							rf_we  = 1'b1;
							set_cc = 1'b1;
							res.reg_index = dr;
							case (it.opcode)
								OP_ADD:  res.reg_value = sr1v + opb;
								OP_AND:  res.reg_value = sr1v & opb;
								OP_NOT:  res.reg_value = ~sr1v;
								default: res.reg_value = addr_pc;
							endcase
						end
						CL_BR: begin
							finish = 1'b1;
							if ((it.bits[11:9] & cc_q) != 3'd0) res.next_pc = addr_pc;
						end
						CL_JMP: begin
							finish = 1'b1;
							res.next_pc = sr1v;
						end
						CL_JSR: begin
							finish = 1'b1;
							rf_we  = 1'b1;
							res.reg_index = 3'd7;
							res.reg_value = pc1;
							res.next_pc = it.bits[11] ?
								pc1 + {{5{it.bits[10]}}, it.bits[10:0]} : sr1v;
						end
						CL_TRAP: begin
							finish = 1'b1;
							case (it.bits[7:0])
								TV_GETC: begin
									rf_we = 1'b1;
									res.reg_value = {8'd0, it.key};
								end
								TV_OUT: begin
									res.char_valid = 1'b1;
									res.char_out   = rf_q[0][7:0];
								end
								TV_IN: begin
									rf_we = 1'b1;
									res.reg_value  = {8'd0, it.key};
									res.char_valid = 1'b1;
									res.char_out   = it.key;
								end
								TV_PUTS, TV_PUTSP: res.status = ST_UNSUP;
								TV_HALT: begin
									halt = 1'b1;
									res.status = ST_HALT;
								end
								default: begin
									halt = 1'b1;
									res.status = ST_BADTRAP;
								end
							endcase
						end
						default: begin
							finish = 1'b1;
							res.status = ST_UNSUP;
						end
					endcase
				end
			end
			S_RD1: begin
				if (it.cls == CL_LDI) begin
					mem_re = 1'b1;
					mem_a  = rdata;
				end else if (out_free) begin
					finish = 1'b1;
					if (it.cls == CL_STI) begin
						mem_we = 1'b1;
						mem_a  = rdata;
					end else begin
						rf_we  = 1'b1;
						set_cc = 1'b1;
						res.reg_index = dr;
						res.reg_value = rdata;
					end
				end
			end
			S_RD2: begin
				if (out_free) begin
					finish = 1'b1;
					rf_we  = 1'b1;
					set_cc = 1'b1;
					res.reg_index = dr;
					res.reg_value = rdata;
				end
			end
			default: ;
		endcase
		res.reg_written = rf_we;
		res.cond_code   = set_cc ? cc_of(res.reg_value) : cc_q;
	end

	assign pop      = finish;
	assign ram_addr = clearing ? clr_q : mem_a[MEM_ADDR_BITS-1:0];
	assign ram_wd   = clearing ? 16'd0 : mem_wd;

	lc3_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we || clearing),
		.re    (mem_re),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (finish) out_data <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			pc_q      <= PC_RESET;
			cc_q      <= CC_ZERO;
			running_q <= 1'b1;
			out_valid <= 1'b0;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (finish) begin
				pc_q <= res.next_pc;
				cc_q <= res.cond_code;
				if (halt) running_q <= 1'b0;
				if (rf_we) rf_q[res.reg_index] <= res.reg_value;
			end
			if (cfg_we) pc_q <= cfg_pc;
			if (finish) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop) else $error("pop during memory clear");
	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> out_free) else $error("result beat overwritten");
	a_rd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD1 && $past(state_q) != S_RD1) |-> $past(mem_re))
		else $error("read state without read");
endmodule
`default_nettype wire

>>> rtl/lc3_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// lc3_instruction_execute_core
// LC-3 instruction execute unit with a queued front end.
// ----------------------------------------------------------------------------
// Register ops finish straight from the queue head; LD/LDR/STI go via S_RD1,
// LDI via S_RD1 and S_RD2 (single data memory port with registered read).
// Throughput: one instruction per cycle for register ops while m_tready is high;
// loads and STI hold later ones. Reset: sets PC to PC_RESET, clears the register
// file, then zeroes data memory; no instruction beat is taken until the sweep ends.
`default_nettype none
module lc3_instruction_execute_core
	import lc3_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[3:0], operand_bits[15:4], key_char[23:16]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// next_pc[15:0], cond_code[18:16], reg_written[19], reg_index[22:20],
	// reg_value[38:23], char_valid[39], char_out[47:40], status[50:48]
	output logic [55:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	head_t   head;
	logic    pop, clearing;
	result_t res;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {5'd0, res};

	lc3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.block        (clearing),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tdata[3:0]),
		.operand_bits (s_tdata[15:4]),
		.key_char     (s_tdata[23:16]),
		.pop          (pop),
		.head         (head)
	);

	lc3_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_pc    (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);
endmodule
`default_nettype wire
